/* rtl/keyboard_macro_player_macros.svh */
// Assertion macros for the keyboard macro player.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef KEYBOARD_MACRO_PLAYER_MACROS_SVH
`define KEYBOARD_MACRO_PLAYER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KMP_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KMP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kmp_pkg.sv */
// Shared types, constants and the microcode table of the keyboard macro player.
// Used by kmp_seq and keyboard_macro_player; depends on nothing.
package kmp_pkg;

    localparam int HOLD_DEPTH_DEF = 16;
    localparam int MOD_COUNT_DEF  = 5;
    localparam int MOD_REGS       = 5;
    localparam int KEY_W          = 16;
    localparam int MASK_W         = 5;
    localparam int MS_W           = 16;
    localparam int US_W           = 26;
    localparam int DELAY_W        = 20;
    localparam int CFG_AW         = 3;
    localparam logic [9:0] MS_TO_US = 10'd1000;

    localparam logic [CFG_AW-1:0] REG_STEP_DELAY = 3'd5;

    localparam logic [MOD_REGS-1:0][KEY_W-1:0] MOD_KEY_RESET = {
        16'd100, 16'd29, 16'd42, 16'd125, 16'd56
    };

    typedef enum logic [1:0] {
        MODE_TAP     = 2'd0,
        MODE_HOLD    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_TIMEOUT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_WAIT    = 2'd2
    } ev_kind_t;

    typedef enum logic [3:0] {
        U_DISPATCH    = 4'd0,
        U_MOD_PRESS   = 4'd1,
        U_MOD_WAIT    = 4'd2,
        U_KEY_PRESS   = 4'd3,
        U_KEY_RELEASE = 4'd4,
        U_MOD_RELEASE = 4'd5,
        U_HOLD        = 4'd6,
        U_RELEASE     = 4'd7,
        U_TIMEOUT     = 4'd8,
        U_STEP_WAIT   = 4'd9
    } ustep_t;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_MOD       = 3'd2,
        C_MASK_STEP = 3'd3,
        C_STEP      = 3'd4,
        C_HELD      = 3'd5
    } cond_t;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_MOD   = 2'd1,
        K_ENTRY = 2'd2,
        K_HELD  = 2'd3
    } key_src_t;

    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_STEP = 2'd1,
        W_MS   = 2'd2
    } wait_src_t;

    typedef enum logic [2:0] {
        L_NEVER    = 3'd0,
        L_NO_STEP  = 3'd1,
        L_KEY_TAIL = 3'd2,
        L_MOD_TAIL = 3'd3,
        L_HELD     = 3'd4,
        L_ALWAYS   = 3'd5
    } last_t;

    typedef enum logic [1:0] {
        LP_NONE = 2'd0,
        LP_MOD  = 2'd1,
        LP_HELD = 2'd2
    } loop_t;

    typedef struct packed {
        ustep_t    next;
        logic      jump_mode;
        logic      done;
        cond_t     cond;
        ev_kind_t  kind;
        key_src_t  key_src;
        wait_src_t wait_src;
        last_t     last_rule;
        loop_t     loop;
        logic      store;
        logic      clear_held;
    } uword_t;

    typedef struct packed {
        logic [MOD_REGS-1:0][KEY_W-1:0] mod_key;
        logic [DELAY_W-1:0]             step_delay;
    } cfg_t;

    typedef struct packed {
        ev_kind_t         kind;
        logic [KEY_W-1:0] key;
        logic [US_W-1:0]  wait_us;
        logic             last;
    } event_t;

    typedef struct packed {
        mode_t             mode;
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic [MS_W-1:0]   wait_ms;
        logic              start;
    } entry_t;

    function automatic uword_t ucode(input ustep_t s);
        uword_t w;
        w = '{next: U_DISPATCH, jump_mode: 1'b0, done: 1'b0, cond: C_NEVER,
              kind: EV_PRESS, key_src: K_NONE, wait_src: W_NONE,
              last_rule: L_NEVER, loop: LP_NONE, store: 1'b0, clear_held: 1'b0};
        unique case (s)
            U_DISPATCH: begin
                w.jump_mode = 1'b1;
            end
            U_MOD_PRESS: begin
                w.next = U_MOD_WAIT; w.cond = C_MOD; w.kind = EV_PRESS;
                w.key_src = K_MOD; w.loop = LP_MOD;
            end
            U_MOD_WAIT: begin
                w.next = U_KEY_PRESS; w.cond = C_MASK_STEP; w.kind = EV_WAIT;
                w.wait_src = W_STEP;
            end
            U_KEY_PRESS: begin
                w.next = U_KEY_RELEASE; w.cond = C_ALWAYS; w.kind = EV_PRESS;
                w.key_src = K_ENTRY;
            end
            U_KEY_RELEASE: begin
                w.next = U_MOD_RELEASE; w.cond = C_ALWAYS; w.kind = EV_RELEASE;
                w.key_src = K_ENTRY; w.last_rule = L_KEY_TAIL;
            end
            U_MOD_RELEASE: begin
                w.next = U_STEP_WAIT; w.cond = C_MOD; w.kind = EV_RELEASE;
                w.key_src = K_MOD; w.last_rule = L_MOD_TAIL; w.loop = LP_MOD;
            end
            U_HOLD: begin
                w.next = U_STEP_WAIT; w.cond = C_ALWAYS; w.kind = EV_PRESS;
                w.key_src = K_ENTRY; w.last_rule = L_NO_STEP; w.store = 1'b1;
            end
            U_RELEASE: begin
                w.next = U_STEP_WAIT; w.cond = C_HELD; w.kind = EV_RELEASE;
                w.key_src = K_HELD; w.last_rule = L_HELD; w.loop = LP_HELD;
                w.clear_held = 1'b1;
            end
            U_TIMEOUT: begin
                w.next = U_STEP_WAIT; w.cond = C_ALWAYS; w.kind = EV_WAIT;
                w.wait_src = W_MS; w.last_rule = L_NO_STEP;
            end
            U_STEP_WAIT: begin
                w.next = U_DISPATCH; w.done = 1'b1; w.cond = C_STEP; w.kind = EV_WAIT;
                w.wait_src = W_STEP; w.last_rule = L_ALWAYS;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic ustep_t mode_target(input mode_t m);
        ustep_t t;
        unique case (m)
            MODE_TAP:     t = U_MOD_PRESS;
            MODE_HOLD:    t = U_HOLD;
            MODE_RELEASE: t = U_RELEASE;
            MODE_TIMEOUT: t = U_TIMEOUT;
        endcase
        return t;
    endfunction

endpackage

/* rtl/kmp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the hold list; depends on nothing.
module kmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/kmp_seq.sv */
// Microcoded sequencer and datapath: steps through the control table per entry
// and emits at most one event per step. Depends on kmp_pkg, kmp_ram and the macro header.
`include "keyboard_macro_player_macros.svh"

module kmp_seq #(
    parameter int HOLD_DEPTH = 16,
    parameter int MOD_COUNT  = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  kmp_pkg::cfg_t    cfg,
    input  logic             entry_valid,
    output logic             entry_ready,
    input  kmp_pkg::entry_t  entry_in,
    output logic             evt_valid,
    input  logic             evt_ready,
    output kmp_pkg::event_t  evt
);
    import kmp_pkg::*;

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int MW = (MOD_COUNT > 1) ? $clog2(MOD_COUNT) : 1;
    localparam int JW = (AW > MW) ? AW : MW;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int XW = ((JW > CW) ? JW : CW) + 1;
    localparam logic [JW-1:0] MOD_LAST = JW'(MOD_COUNT - 1);

    logic             busy_reg, busy_next;
    ustep_t           step_reg, step_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [CW-1:0]    count_reg, count_next;
    entry_t           entry_reg;

    uword_t            uw;
    logic [MOD_REGS-1:0] active;
    logic              cur_active, any_above, any_active;
    logic [KEY_W-1:0]  mod_key_cur;
    logic [KEY_W-1:0]  held_key;
    logic [US_W-1:0]   ms_us;
    logic              step_nz;
    logic              cond_ok, more, advance, last_ok;
    logic              ram_we;
    logic [XW-1:0]     j_x, cnt_x;

    assign entry_ready = !busy_reg;
    assign uw          = ucode(step_reg);
    assign step_nz     = cfg.step_delay != '0;
    assign j_x         = XW'(j_reg);
    assign cnt_x       = XW'(count_reg);
    assign ms_us       = {10'b0, entry_reg.wait_ms} * {16'b0, MS_TO_US};

    always_comb begin
        active      = '0;
        cur_active  = 1'b0;
        any_above   = 1'b0;
        mod_key_cur = '0;
        for (int i = 0; i < MOD_REGS; i++) begin
            if (i < MOD_COUNT) begin
                active[i] = entry_reg.mask[i] && (cfg.mod_key[i] != '0);
                if (j_reg == JW'(i)) begin
                    mod_key_cur = cfg.mod_key[i];
                    cur_active  = active[i];
                end
                if (active[i] && (JW'(i) > j_reg)) begin
                    any_above = 1'b1;
                end
            end
        end
        any_active = |active;
    end

    always_comb begin
        unique case (uw.cond)
            C_NEVER:     cond_ok = 1'b0;
            C_ALWAYS:    cond_ok = 1'b1;
            C_MOD:       cond_ok = cur_active;
            C_MASK_STEP: cond_ok = (entry_reg.mask != '0) && step_nz;
            C_STEP:      cond_ok = step_nz;
            C_HELD:      cond_ok = j_x < cnt_x;
            default:     cond_ok = 1'b0;
        endcase

        unique case (uw.loop)
            LP_NONE: more = 1'b0;
            LP_MOD:  more = j_reg != MOD_LAST;
            LP_HELD: more = (j_x + XW'(1)) < cnt_x;
            default: more = 1'b0;
        endcase

        unique case (uw.last_rule)
            L_NEVER:    last_ok = 1'b0;
            L_NO_STEP:  last_ok = !step_nz;
            L_KEY_TAIL: last_ok = !step_nz && !any_active;
            L_MOD_TAIL: last_ok = !step_nz && !any_above;
            L_HELD:     last_ok = !step_nz && ((j_x + XW'(1)) == cnt_x);
            L_ALWAYS:   last_ok = 1'b1;
            default:    last_ok = 1'b0;
        endcase

        evt.kind = uw.kind;
        evt.last = last_ok;
        unique case (uw.key_src)
            K_NONE:  evt.key = '0;
            K_MOD:   evt.key = mod_key_cur;
            K_ENTRY: evt.key = entry_reg.key;
            K_HELD:  evt.key = held_key;
        endcase
        unique case (uw.wait_src)
            W_NONE:  evt.wait_us = '0;
            W_STEP:  evt.wait_us = US_W'(cfg.step_delay);
            W_MS:    evt.wait_us = ms_us;
            default: evt.wait_us = '0;
        endcase
    end

    assign evt_valid = busy_reg && cond_ok;
    assign advance   = busy_reg && (!cond_ok || evt_ready);
    assign ram_we    = advance && uw.store && (count_reg < CW'(HOLD_DEPTH));

    always_comb begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        j_next     = j_reg;
        count_next = count_reg;
        if (!busy_reg) begin
            if (entry_valid) begin
                busy_next = 1'b1;
                if (entry_in.start) begin
                    count_next = '0;
                end
            end
        end else if (advance) begin
            if (more) begin
                j_next = j_reg + JW'(1);
            end else begin
                j_next    = '0;
                step_next = uw.jump_mode ? mode_target(entry_reg.mode) : uw.next;
                if (uw.done) begin
                    busy_next = 1'b0;
                end
                if (uw.clear_held) begin
                    count_next = '0;
                end
            end
            if (ram_we) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            step_reg  <= U_DISPATCH;
            j_reg     <= '0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            j_reg     <= j_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && entry_valid) begin
            entry_reg <= entry_in;
        end
    end

    kmp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (entry_reg.key),
        .raddr (j_next[AW-1:0]),
        .rdata (held_key)
    );

    `KMP_ASSERT(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(HOLD_DEPTH), "hold count overflow")
    `KMP_ASSERT(a_idle_home, aclk, aresetn, !busy_reg, (step_reg == U_DISPATCH) && (j_reg == '0), "idle sequencer off its home step")
    `KMP_ASSERT_NEXT(a_held_cleared, aclk, aresetn, advance && !more && uw.clear_held, count_reg == '0, "hold list not emptied after release")

endmodule

/* rtl/keyboard_macro_player.sv */
// Keyboard macro player: one entry in, a run of press/release/wait events out.
// An accepted entry passes a dispatch step, then the microcode steps of its mode,
// emitting at most one event per cycle unless m_tready stalls the output register.
// The first event passes the dispatch step and the output register before m_tvalid;
// a tap may also pass skipped steps first. A stall on m_tready holds the sequencer.
// Reset (aresetn low, synchronous): hold list empty, sequencer and config at defaults.
`include "keyboard_macro_player_macros.svh"

module keyboard_macro_player #(
    parameter int HOLD_DEPTH = kmp_pkg::HOLD_DEPTH_DEF,
    parameter int MOD_COUNT  = kmp_pkg::MOD_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [kmp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [kmp_pkg::DELAY_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // key_code, mod_mask, wait_ms
    input  logic [2:0]                    s_tuser,   // mode, macro_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // event_key, wait_us
    output logic [1:0]                    m_tuser,   // event_kind
    output logic                          m_tlast
);
    import kmp_pkg::*;

    cfg_t   cfg_reg;
    entry_t entry_in;
    event_t evt, out_reg;
    logic   evt_valid, evt_ready;
    logic   out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mod_key    <= MOD_KEY_RESET;
            cfg_reg.step_delay <= '0;
        end else if (cfg_we) begin
            for (int i = 0; i < MOD_REGS; i++) begin
                if (cfg_addr == CFG_AW'(i)) begin
                    cfg_reg.mod_key[i] <= cfg_wdata[KEY_W-1:0];
                end
            end
            if (cfg_addr == REG_STEP_DELAY) begin
                cfg_reg.step_delay <= cfg_wdata;
            end
        end
    end

    assign entry_in.mode    = mode_t'(s_tuser[1:0]);
    assign entry_in.start   = s_tuser[2];
    assign entry_in.key     = s_tdata[15:0];
    assign entry_in.mask    = s_tdata[20:16];
    assign entry_in.wait_ms = s_tdata[36:21];

    kmp_seq #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .MOD_COUNT  (MOD_COUNT)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .entry_valid (s_tvalid),
        .entry_ready (s_tready),
        .entry_in    (entry_in),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt)
    );

    assign evt_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (evt_ready) begin
            out_valid_reg <= evt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_ready && evt_valid) begin
            out_reg <= evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.wait_us, out_reg.key};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    `KMP_ASSERT_NEXT(a_event_loaded, aclk, aresetn, evt_valid && evt_ready, m_tvalid, "event lost at output register")
    `KMP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word dropped or changed while stalled")
    `KMP_ASSERT_NEXT(a_in_one_word, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while an entry is in flight")

endmodule

/* tb/keyboard_macro_player_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for keyboard_macro_player: drives macro entries in
// and checks every press, release and wait word against an event predictor.
// Depends on kmp_pkg and the keyboard_macro_player RTL only.
module keyboard_macro_player_tb;
    import kmp_pkg::*;

    localparam logic [CFG_AW-1:0] REG_MOD_BASE = 3'd0;

    class kmp_event_scoreboard;
        logic [KEY_W-1:0]   mod_key [MOD_REGS];
        logic [DELAY_W-1:0] step_delay;
        logic [KEY_W-1:0]   held_keys [HOLD_DEPTH_DEF];
        int                 held_count;
        event_t             due_events [$];
        int                 mismatches;
        int                 entries;
        int                 events_seen;
        int                 overflows;

        function new();
            for (int j = 0; j < MOD_REGS; j++) mod_key[j] = MOD_KEY_RESET[j];
            step_delay  = '0;
            held_count  = 0;
            mismatches  = 0;
            entries     = 0;
            events_seen = 0;
            overflows   = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] addr, logic [DELAY_W-1:0] value);
            if (addr == REG_STEP_DELAY)
                step_delay = value;
            else if (addr < MOD_REGS)
                mod_key[addr] = value[KEY_W-1:0];
        endfunction

        function void queue_event(ev_kind_t kind, logic [KEY_W-1:0] key,
                                  logic [US_W-1:0] us);
            event_t ev;
            ev = '{kind: kind, key: key, wait_us: us, last: 1'b0};
            due_events.push_back(ev);
        endfunction

        function void play_entry(entry_t e);
            int     first;
            event_t ev;
            first = due_events.size();
            entries++;
            if (e.start)
                held_count = 0;
            case (e.mode)
                MODE_TAP: begin
                    for (int j = 0; j < MOD_COUNT_DEF && j < MOD_REGS; j++)
                        if (e.mask[j] && mod_key[j] != 0)
                            queue_event(EV_PRESS, mod_key[j], '0);
                    if (e.mask != 0 && step_delay != 0)
                        queue_event(EV_WAIT, '0, US_W'(step_delay));
                    queue_event(EV_PRESS, e.key, '0);
                    queue_event(EV_RELEASE, e.key, '0);
                    for (int j = 0; j < MOD_COUNT_DEF && j < MOD_REGS; j++)
                        if (e.mask[j] && mod_key[j] != 0)
                            queue_event(EV_RELEASE, mod_key[j], '0);
                end
                MODE_HOLD: begin
                    queue_event(EV_PRESS, e.key, '0);
                    if (held_count < HOLD_DEPTH_DEF) begin
                        held_keys[held_count] = e.key;
                        held_count++;
                    end else begin
                        overflows++;
                    end
                end
                MODE_RELEASE: begin
                    for (int k = 0; k < held_count; k++)
                        queue_event(EV_RELEASE, held_keys[k], '0);
                    held_count = 0;
                end
                default: begin
                    queue_event(EV_WAIT, '0, US_W'(e.wait_ms) * US_W'(MS_TO_US));
                end
            endcase
            if (step_delay != 0)
                queue_event(EV_WAIT, '0, US_W'(step_delay));
            if (due_events.size() > first) begin
                ev = due_events[due_events.size()-1];
                ev.last = 1'b1;
                due_events[due_events.size()-1] = ev;
            end
        endfunction

        function void check_event(event_t got);
            event_t want;
            if (due_events.size() == 0) begin
                $display("%0t: unexpected word kind %0d key %h wait %0d last %0d",
                         $time, got.kind, got.key, got.wait_us, got.last);
                mismatches++;
                return;
            end
            want = due_events.pop_front();
            events_seen++;
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                mismatches++;
            end
            if (got.key !== want.key) begin
                $display("%0t: key expected %h actual %h", $time, want.key, got.key);
                mismatches++;
            end
            if (got.wait_us !== want.wait_us) begin
                $display("%0t: wait_us expected %0d actual %0d",
                         $time, want.wait_us, got.wait_us);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                mismatches++;
            end
        endfunction

        function int pending();
            return due_events.size();
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr  = '0;
    logic [DELAY_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;   // key_code, mod_mask, wait_ms
    logic [2:0]         s_tuser   = '0;   // mode, macro_start
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [47:0]        m_tdata;          // event_key, wait_us
    logic [1:0]         m_tuser;          // event_kind
    logic               m_tlast;

    logic               calm        = 1'b0;
    logic               stall_req   = 1'b0;
    logic               stall_taken = 1'b0;
    int                 stall_left  = 0;
    int                 settings    = 1;

    kmp_event_scoreboard board = new();

    keyboard_macro_player dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("keyboard_macro_player test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_req && !stall_taken) begin
            m_tready    <= 1'b0;
            stall_left  <= 400;
            stall_taken <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge aclk) begin
        event_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = ev_kind_t'(m_tuser);
            got.key     = m_tdata[KEY_W-1:0];
            got.wait_us = m_tdata[KEY_W +: US_W];
            got.last    = m_tlast;
            board.check_event(got);
        end
    end

    function automatic entry_t make_entry(mode_t m, logic [KEY_W-1:0] key,
                                          logic [MASK_W-1:0] mask,
                                          logic [MS_W-1:0] ms, logic start);
        entry_t e;
        e.mode    = m;
        e.key     = key;
        e.mask    = mask;
        e.wait_ms = ms;
        e.start   = start;
        return e;
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_entry(input entry_t e);
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, e.wait_ms, e.mask, e.key};
        s_tuser  <= {e.start, e.mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.play_entry(e);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [MOD_REGS-1:0][KEY_W-1:0] keys,
                                 input logic [DELAY_W-1:0] delay);
        for (int j = 0; j <= MOD_REGS; j++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= (j == MOD_REGS) ? REG_STEP_DELAY : REG_MOD_BASE + CFG_AW'(j);
            cfg_wdata <= (j == MOD_REGS) ? delay : DELAY_W'(keys[j]);
            @(posedge aclk);
            board.set_reg((j == MOD_REGS) ? REG_STEP_DELAY : REG_MOD_BASE + CFG_AW'(j),
                          (j == MOD_REGS) ? delay : DELAY_W'(keys[j]));
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic play_random(input int count);
        int     sent;
        int     len;
        int     r;
        bit     burst;
        entry_t e;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(0, 99) < 15;
            len   = burst ? $urandom_range(17, 20) : $urandom_range(2, 20);
            for (int k = 0; k < len && sent < count; k++) begin
                e.key     = pick_word();
                e.wait_ms = pick_word();
                e.mask    = MASK_W'($urandom_range(0, 31));
                e.start   = (k == 0) ? ($urandom_range(0, 9) != 0)
                                     : ($urandom_range(0, 29) == 0);
                if (burst) begin
                    e.mode = (k == len - 1) ? MODE_RELEASE : MODE_HOLD;
                end else if (k == len - 1 && $urandom_range(0, 1) == 1) begin
                    e.mode = MODE_RELEASE;
                end else begin
                    r = $urandom_range(0, 99);
                    e.mode = (r < 40) ? MODE_TAP : (r < 70) ? MODE_HOLD :
                             (r < 82) ? MODE_RELEASE : MODE_TIMEOUT;
                end
                send_entry(e);
                sent++;
            end
        end
    endtask

    initial begin
        logic [MOD_REGS-1:0][KEY_W-1:0] keys;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_entry(make_entry(MODE_TAP, 16'h0000, 5'h00, 16'h0000, 1'b1));
        send_entry(make_entry(MODE_TAP, 16'hFFFF, 5'h1F, 16'hFFFF, 1'b0));
        send_entry(make_entry(MODE_TAP, 16'h1234, 5'h05, 16'h0000, 1'b0));
        send_entry(make_entry(MODE_RELEASE, 16'hFFFF, 5'h1F, 16'hFFFF, 1'b0));
        send_entry(make_entry(MODE_TIMEOUT, 16'h0000, 5'h00, 16'h0000, 1'b0));
        send_entry(make_entry(MODE_TIMEOUT, 16'hFFFF, 5'h00, 16'hFFFF, 1'b1));
        for (int k = 0; k < 17; k++)
            send_entry(make_entry(MODE_HOLD,
                                  (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : pick_word(),
                                  MASK_W'($urandom_range(0, 31)), pick_word(), 1'b0));
        send_entry(make_entry(MODE_RELEASE, 16'h0000, 5'h00, 16'h0000, 1'b0));
        send_entry(make_entry(MODE_RELEASE, 16'h0000, 5'h00, 16'h0000, 1'b0));
        drain();

        play_random(60);
        drain();

        apply_setting({MOD_REGS{16'hFFFF}}, 20'hFFFFF);
        play_random(38);
        drain();
        play_random(38);
        drain();

        apply_setting('0, 20'd1);
        stall_req <= 1'b1;
        play_random(76);
        drain();

        for (int j = 0; j < MOD_REGS; j++)
            keys[j] = ($urandom_range(0, 3) == 0) ? 16'h0000 : pick_word();
        apply_setting(keys, DELAY_W'($urandom_range(0, 1048575)));
        calm <= 1'b1;
        play_random(40);
        calm <= 1'b0;
        play_random(36);
        drain();

        for (int j = 0; j < MOD_REGS; j++)
            keys[j] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'h0001;
        apply_setting(keys, 20'd1000000);
        play_random(76);
        drain();

        $display("Covered %0d entries and %0d events under %0d register settings,",
                 board.entries, board.events_seen, settings);
        $display("with %0d holds against a full list and one long output stall.",
                 board.overflows);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("keyboard_macro_player test passed");
        else
            $display("keyboard_macro_player test failed");
        $finish;
    end
endmodule
